// ----- sv/salru_pkg.sv -----
// Package with the geometry, row layout and helpers of the set-associative LRU tag cache.
`timescale 1ns / 1ps

package salru_pkg;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int ADDR_BITS   = 64;

  function automatic int floor_log2(input int v);
    int r;
    r = 0;
    while (r < 31 && (64'(1) << (r + 1)) <= 64'(v)) begin
      r++;
    end
    return r;
  endfunction

  localparam int OFF_BITS = floor_log2(BLOCK_BYTES);
  localparam int IDX_BITS = floor_log2(SETS);
  localparam int NUM_ROWS = 1 << IDX_BITS;
  localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int TAG_RAW  = ADDR_BITS - OFF_BITS - IDX_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [WAY_W-1:0] way_t;
  typedef logic [SET_W-1:0] set_t;

  // Position 0 of the order is the most recent way.
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][WAY_W-1:0] order;
  } row_t;

  typedef struct packed {
    logic hit;
    way_t way;
    logic replaced;
  } result_t;

  function automatic row_t reset_row();
    row_t r;
    r.tag   = '0;
    r.valid = '0;
    for (int j = 0; j < WAYS; j++) begin
      r.order[j] = WAY_W'(j);
    end
    return r;
  endfunction

endpackage

// ----- sv/salru_lookup.sv -----
// Tag compare, way selection and true LRU update of one cache set.
`timescale 1ns / 1ps

module salru_lookup (
  input  salru_pkg::row_t    row_i,
  input  salru_pkg::tag_t    tag_i,
  input  logic               is_write_i,
  output salru_pkg::result_t res_o,
  output salru_pkg::row_t    row_o
);

  logic             hit_found;
  logic             inv_found;
  salru_pkg::way_t  hit_way;
  salru_pkg::way_t  inv_way;
  salru_pkg::way_t  victim;
  salru_pkg::way_t  sel_way;
  logic [salru_pkg::WAY_W:0] pos;
  logic             pos_found;

  always_comb begin
    hit_found = 1'b0;
    inv_found = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    for (int w = 0; w < salru_pkg::WAYS; w++) begin
      if (!hit_found && row_i.tag[w] == tag_i && (is_write_i || row_i.valid[w])) begin
        hit_found = 1'b1;
        hit_way   = salru_pkg::WAY_W'(w);
      end
      if (!inv_found && !row_i.valid[w]) begin
        inv_found = 1'b1;
        inv_way   = salru_pkg::WAY_W'(w);
      end
    end

    victim = row_i.order[salru_pkg::WAYS-1];
    if (32'(victim) >= 32'(salru_pkg::WAYS)) begin
      victim = salru_pkg::WAY_W'(salru_pkg::WAYS - 1);
    end

    res_o.hit      = hit_found;
    res_o.replaced = !hit_found && !inv_found;
    if (hit_found) begin
      sel_way = hit_way;
    end else if (inv_found) begin
      sel_way = inv_way;
    end else begin
      sel_way = victim;
    end
    res_o.way = sel_way;

    row_o = row_i;
    row_o.valid[sel_way] = 1'b1;
    if (!hit_found) begin
      row_o.tag[sel_way] = tag_i;
    end

    // The way moves to the front; entries ahead of its old position shift back by one.
    pos       = (salru_pkg::WAY_W + 1)'(salru_pkg::WAYS - 1);
    pos_found = 1'b0;
    for (int p = 0; p < salru_pkg::WAYS - 1; p++) begin
      if (!pos_found && row_i.order[p] == sel_way) begin
        pos_found = 1'b1;
        pos       = (salru_pkg::WAY_W + 1)'(p);
      end
    end
    row_o.order[0] = sel_way;
    for (int i = 1; i < salru_pkg::WAYS; i++) begin
      if ((salru_pkg::WAY_W + 1)'(i) <= pos) begin
        row_o.order[i] = row_i.order[i-1];
      end else begin
        row_o.order[i] = row_i.order[i];
      end
    end
  end

endmodule

// ----- sv/set_assoc_lru_cache_tags.sv -----
// Top level of the tag-only set-associative cache with true LRU replacement.
`timescale 1ns / 1ps

// Each item is a read or write to a byte address and yields one result: hit, the way that
// hit or was filled, and whether a valid line was evicted. An item first reads its set's
// row (tags, valid bits, recency order) from the single-port set memory, then compares
// tags, picks the way, updates the order and writes the row back. A new item is taken
// only while no item is in flight; a result that waits on a stall keeps the block in its
// lookup state. Each set has a flip-flop that marks its row as written, so the cache is
// ready right after reset with no clearing pass.

module set_assoc_lru_cache_tags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [63:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [1:0]  way_used_o,
  output logic        replaced_valid_o
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e             state_q;
  logic               out_valid_q;
  logic               hit_q;
  logic [1:0]         way_q;
  logic               repl_q;
  logic               write_q;
  salru_pkg::tag_t    tag_q;
  salru_pkg::set_t    set_q;
  logic               rd_vld_q;
  logic [salru_pkg::NUM_ROWS-1:0] row_vld_q;

  salru_pkg::row_t    mem_q [salru_pkg::NUM_ROWS];
  salru_pkg::row_t    rd_data_q;
  salru_pkg::row_t    cur_row;
  salru_pkg::row_t    new_row;
  salru_pkg::result_t res;

  logic [63:0]        addr_m;
  salru_pkg::set_t    in_set;
  salru_pkg::tag_t    in_tag;
  logic               in_acc;
  logic               out_free;
  logic               finish;

  always_comb begin
    addr_m = address_i;
    if (salru_pkg::ADDR_BITS < 64) begin
      addr_m = address_i & ((64'(1) << (salru_pkg::ADDR_BITS % 64)) - 64'(1));
    end
    if (salru_pkg::IDX_BITS > 0) begin
      in_set = salru_pkg::SET_W'(addr_m >> salru_pkg::OFF_BITS);
    end else begin
      in_set = '0;
    end
    in_tag = salru_pkg::TAG_W'(addr_m >> (salru_pkg::OFF_BITS + salru_pkg::IDX_BITS));
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_LOOKUP) && out_free;
  assign cur_row    = rd_vld_q ? rd_data_q : salru_pkg::reset_row();

  salru_lookup u_lookup (
    .row_i      (cur_row),
    .tag_i      (tag_q),
    .is_write_i (write_q),
    .res_o      (res),
    .row_o      (new_row)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= mem_q[in_set];
      tag_q     <= in_tag;
      write_q   <= action_i;
      set_q     <= in_set;
    end
    if (finish) begin
      mem_q[set_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      way_q       <= '0;
      repl_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_acc) begin
            rd_vld_q <= row_vld_q[in_set];
            state_q  <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            hit_q            <= res.hit;
            way_q            <= 2'(res.way);
            repl_q           <= res.replaced;
            row_vld_q[set_q] <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign way_used_o       = way_q;
  assign replaced_valid_o = repl_q;

endmodule

// ----- test/set_assoc_lru_cache_tags_tb.sv -----
// Testbench for the set-associative LRU tag cache: random and directed accesses.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags_tb;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam int   CYCLE_LIMIT = 300000;
  localparam int   RANDOM_PHASES = 6;
  localparam int   PHASE_ITEMS = 100;

  typedef struct {
    logic       hit;
    logic [1:0] way;
    logic       evicted;
  } lookup_t;

  class lru_lookup_scoreboard;
    salru_pkg::tag_t tag_mem[salru_pkg::SETS][salru_pkg::WAYS];
    bit              valid_mem[salru_pkg::SETS][salru_pkg::WAYS];
    int unsigned     order_mem[salru_pkg::SETS][salru_pkg::WAYS];
    lookup_t         expected_q[$];
    int unsigned     mismatches;
    int unsigned     reads;
    int unsigned     writes;
    int unsigned     hits;
    int unsigned     evictions;

    function new();
      for (int s = 0; s < salru_pkg::SETS; s++) begin
        for (int w = 0; w < salru_pkg::WAYS; w++) begin
          tag_mem[s][w]   = '0;
          valid_mem[s][w] = 1'b0;
          order_mem[s][w] = w;
        end
      end
      mismatches = 0;
      reads      = 0;
      writes     = 0;
      hits       = 0;
      evictions  = 0;
    endfunction

    // Position 0 of the order is the most recent way.
    function void make_newest(int unsigned s, int unsigned w);
      int unsigned pos;
      pos = 0;
      while (pos < salru_pkg::WAYS - 1 && order_mem[s][pos] != w) pos++;
      for (int unsigned i = pos; i > 0; i--) order_mem[s][i] = order_mem[s][i - 1];
      order_mem[s][0] = w;
    endfunction

    function void note_access(logic act, logic [63:0] addr);
      logic [63:0]     a;
      salru_pkg::tag_t t;
      int unsigned     s;
      int unsigned     victim;
      lookup_t         r;
      bit              done;
      a = addr;
      if (salru_pkg::ADDR_BITS < 64) a &= (64'd1 << salru_pkg::ADDR_BITS) - 64'd1;
      t = salru_pkg::tag_t'(a >> (salru_pkg::OFF_BITS + salru_pkg::IDX_BITS));
      s = int'((a >> salru_pkg::OFF_BITS) & ((64'd1 << salru_pkg::IDX_BITS) - 64'd1));
      if (s >= salru_pkg::SETS) s = salru_pkg::SETS - 1;
      done = 1'b0;
      for (int w = 0; w < salru_pkg::WAYS; w++) begin
        if (!done && tag_mem[s][w] == t && (act || valid_mem[s][w])) begin
          valid_mem[s][w] = 1'b1;
          make_newest(s, w);
          r = '{1'b1, 2'(w), 1'b0};
          done = 1'b1;
        end
      end
      for (int w = 0; w < salru_pkg::WAYS; w++) begin
        if (!done && !valid_mem[s][w]) begin
          valid_mem[s][w] = 1'b1;
          tag_mem[s][w]   = t;
          make_newest(s, w);
          r = '{1'b0, 2'(w), 1'b0};
          done = 1'b1;
        end
      end
      if (!done) begin
        victim = order_mem[s][salru_pkg::WAYS - 1];
        if (victim >= salru_pkg::WAYS) victim = salru_pkg::WAYS - 1;
        tag_mem[s][victim]   = t;
        valid_mem[s][victim] = 1'b1;
        make_newest(s, victim);
        r = '{1'b0, 2'(victim), 1'b1};
        evictions++;
      end
      if (r.hit) hits++;
      if (act) writes++;
      else reads++;
      expected_q = {expected_q, r};
    endfunction

    function void check_lookup(logic hit, logic [1:0] way, logic evicted);
      lookup_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b way_used=%0d replaced_valid=%0b",
                 $time, hit, way, evicted);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
        mismatches++;
      end
      if (way !== e.way) begin
        $display("%0t: way_used expected %0d actual %0d", $time, e.way, way);
        mismatches++;
      end
      if (evicted !== e.evicted) begin
        $display("%0t: replaced_valid expected %0b actual %0b", $time, e.evicted, evicted);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = ACT_READ;
  logic [63:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o;
  logic [1:0]  way_used_o;
  logic        replaced_valid_o;

  lru_lookup_scoreboard sb;
  bit          idle_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  set_assoc_lru_cache_tags DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .way_used_o       (way_used_o),
    .replaced_valid_o (replaced_valid_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL set_assoc_lru_cache_tags");
      $finish;
    end
  end

  // Result side: check accepted results, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_lookup(hit_o, way_used_o, replaced_valid_o);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [63:0] make_addr(logic [63:0] t, int unsigned s, int unsigned o);
    return (t << (salru_pkg::OFF_BITS + salru_pkg::IDX_BITS)) |
           (64'(s) << salru_pkg::OFF_BITS) | 64'(o);
  endfunction

  task automatic access(input logic act, input logic [63:0] addr);
    int unsigned gap;
    in_valid_i <= 1'b1;
    action_i   <= act;
    address_i  <= addr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_access(act, addr);
    gap = 0;
    if (idle_on && $urandom_range(0, 1) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [63:0] tag_pool[6];
    int unsigned set_pool[3];
    logic [63:0] tag_max;
    sb = new();
    tag_max = 64'(salru_pkg::tag_t'('1));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b1;
    access(ACT_READ, '0);
    access(ACT_WRITE, make_addr(64'd0, 1, 5));
    access(ACT_READ, make_addr(64'd0, 1, 0));
    access(ACT_READ, make_addr(64'd0, salru_pkg::SETS - 1, 0));
    access(ACT_READ, '1);
    access(ACT_WRITE, '1);
    access(ACT_WRITE, make_addr(tag_max, 0, 0));
    access(ACT_READ, 64'h8000_0000_0000_0000);
    for (int t = 1; t <= 4; t++) access(ACT_READ, make_addr(64'(t), 2, 0));
    access(ACT_WRITE, make_addr(64'd5, 2, salru_pkg::BLOCK_BYTES - 1));
    access(ACT_READ, make_addr(64'd3, 2, 1));
    access(ACT_READ, make_addr(64'd1, 2, 0));
    access(ACT_WRITE, make_addr(64'd2, 2, 0));
    access(ACT_READ, make_addr(64'd4, 2, 7));
    access(ACT_READ, make_addr(64'd0, 0, salru_pkg::BLOCK_BYTES - 1));
    access(ACT_WRITE, make_addr(64'd0, 2, 0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != 0);
      for (int i = 0; i < 3; i++) begin
        set_pool[i] = (i == 0 && p % 2 == 1) ? salru_pkg::SETS - 1
                                             : $urandom_range(0, salru_pkg::SETS - 1);
      end
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(0, 2))
          0: tag_pool[i] = (i == 0) ? 64'd0 : 64'($urandom_range(1, 15));
          1: tag_pool[i] = 64'(salru_pkg::tag_t'({$urandom, $urandom}));
          default: tag_pool[i] = tag_max ^ 64'($urandom_range(0, 7));
        endcase
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          access(1'($urandom_range(0, 1)),
                 make_addr(tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 2)],
                           $urandom_range(0, salru_pkg::BLOCK_BYTES - 1)));
        end else begin
          access(1'($urandom_range(0, 1)), {$urandom, $urandom});
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d reads and %0d writes: %0d hits, %0d evictions of valid lines.",
             sb.reads, sb.writes, sb.hits, sb.evictions);
    $display("Random phases used hot sets with small tag pools plus fully random addresses.");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS set_assoc_lru_cache_tags");
    end else begin
      $display("FAIL set_assoc_lru_cache_tags");
    end
    $finish;
  end

endmodule
